// File: src/aod_pkg.sv
// Package for the accelerometer orientation detector.
// Holds event and orientation codes, register indexes, datapath command types
// and the CORDIC step angle table. No dependencies.
package aod_pkg;

    localparam int EV_TYPE_W  = 16;
    localparam int EV_CODE_W  = 16;
    localparam int EV_VALUE_W = 32;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 8;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int DEG_W      = 7;
    localparam int ROOT_FRAC  = 8;
    localparam int MAX_DEG    = 90;
    localparam int ANG_TBL_W  = 22;
    localparam int ANG_FRAC   = 16;
    localparam int ANG_IDX_W  = 5;

    localparam logic [EV_TYPE_W-1:0] EV_SYN = 16'd0;
    localparam logic [EV_TYPE_W-1:0] EV_ABS = 16'd3;
    localparam logic [EV_CODE_W-1:0] REPORT_CODE = 16'd0;
    localparam logic [EV_CODE_W-1:0] ABS_X = 16'd0;
    localparam logic [EV_CODE_W-1:0] ABS_Y = 16'd1;
    localparam logic [EV_CODE_W-1:0] ABS_Z = 16'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PORTRAIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDSCAPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAME_AXIS = 2'd2;

    localparam logic [CFG_W-1:0] PORTRAIT_RST  = 7'd20;
    localparam logic [CFG_W-1:0] LANDSCAPE_RST = 7'd25;
    localparam logic [CFG_W-1:0] SAME_AXIS_RST = 7'd5;

    typedef logic [2:0] orient_t;
    localparam orient_t ORIENT_UNDEF  = 3'd0;
    localparam orient_t ORIENT_NORMAL = 3'd1;
    localparam orient_t ORIENT_BOTTOM = 3'd2;
    localparam orient_t ORIENT_LEFT   = 3'd3;
    localparam orient_t ORIENT_RIGHT  = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SQ_B,
        OP_SQ_C,
        OP_SUM,
        OP_ROOT,
        OP_CINIT,
        OP_ROT,
        OP_ROUND,
        OP_DECIDE,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   tilt_y;
    } dp_cmd_t;

    typedef struct packed {
        logic complete;
        logic zero_vec;
        logic exceeds;
        logic out_free;
    } dp_status_t;

    // atan(2^-i) in degrees, 16 fractional bits
    function automatic logic [ANG_TBL_W-1:0] step_angle(input logic [ANG_IDX_W-1:0] idx);
        logic [ANG_TBL_W-1:0] a;
        unique case (idx)
            5'd0:    a = 22'd2949120;
            5'd1:    a = 22'd1740967;
            5'd2:    a = 22'd919879;
            5'd3:    a = 22'd466945;
            5'd4:    a = 22'd234379;
            5'd5:    a = 22'd117304;
            5'd6:    a = 22'd58666;
            5'd7:    a = 22'd29335;
            5'd8:    a = 22'd14668;
            5'd9:    a = 22'd7334;
            5'd10:   a = 22'd3667;
            5'd11:   a = 22'd1833;
            5'd12:   a = 22'd917;
            5'd13:   a = 22'd458;
            5'd14:   a = 22'd229;
            5'd15:   a = 22'd115;
            5'd16:   a = 22'd57;
            5'd17:   a = 22'd29;
            5'd18:   a = 22'd14;
            5'd19:   a = 22'd7;
            5'd20:   a = 22'd4;
            5'd21:   a = 22'd2;
            5'd22:   a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

// File: src/aod_ctrl.sv
// Sequencer for the orientation detector: event intake, tilt passes, result hand-off.
// Depends on aod_pkg.
module aod_ctrl #(
    parameter int ROOT_STEPS   = 24,
    parameter int CORDIC_STEPS = 16,
    parameter int CNT_W        = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  aod_pkg::dp_status_t status,
    output aod_pkg::dp_cmd_t    cmd,
    output logic [CNT_W-1:0]    step
);
    import aod_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_ZCHK   = 11'b00000000010,
        ST_SQ_B   = 11'b00000000100,
        ST_SQ_C   = 11'b00000001000,
        ST_SUM    = 11'b00000010000,
        ST_ROOT   = 11'b00000100000,
        ST_CINIT  = 11'b00001000000,
        ST_ROT    = 11'b00010000000,
        ST_ROUND  = 11'b00100000000,
        ST_DECIDE = 11'b01000000000,
        ST_EMIT   = 11'b10000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             tilt_y_reg, tilt_y_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        tilt_y_next = tilt_y_reg;
        cmd.op      = OP_NONE;
        cmd.tilt_y  = tilt_y_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = OP_CAPTURE;
                    if (status.complete)
                    begin
                        state_next  = ST_ZCHK;
                        tilt_y_next = 1'b0;
                    end
                end
            end
            ST_ZCHK:
            begin
                state_next = status.zero_vec ? ST_EMIT : ST_SQ_B;
            end
            ST_SQ_B:
            begin
                cmd.op     = OP_SQ_B;
                state_next = ST_SQ_C;
            end
            ST_SQ_C:
            begin
                cmd.op     = OP_SQ_C;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = OP_SUM;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.op = OP_ROOT;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_CINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CINIT:
            begin
                cmd.op     = OP_CINIT;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cmd.op = OP_ROT;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                cmd.op     = OP_ROUND;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.op = OP_DECIDE;
                if (!tilt_y_reg && !status.exceeds)
                begin
                    tilt_y_next = 1'b1;
                    state_next  = ST_SQ_B;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign step = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            tilt_y_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            tilt_y_reg <= tilt_y_next;
        end
    end

endmodule

// File: src/aod_datapath.sv
// Datapath: config registers, axis capture, squarer, bit-serial root, CORDIC,
// decision logic and output register. Depends on aod_pkg.
module aod_datapath #(
    parameter int AXIS_BITS       = 16,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CNT_W           = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aod_pkg::CFG_W-1:0]         cfg_data,
    input  logic [aod_pkg::S_DATA_W-1:0]      s_tdata,
    input  aod_pkg::dp_cmd_t                  cmd,
    input  logic [CNT_W-1:0]                  step,
    output aod_pkg::dp_status_t               status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [aod_pkg::M_DATA_W-1:0]      m_tdata
);
    import aod_pkg::*;

    localparam int A    = AXIS_BITS;
    localparam int F    = ANGLE_FRAC_BITS;
    localparam int RW   = AXIS_BITS + ROOT_FRAC;
    localparam int CW   = RW + 3;
    localparam int AW   = F + 10;
    localparam int SQ_W = 2 * A;
    localparam logic signed [AW-1:0] ANG_LIM  = AW'(MAX_DEG << F);
    localparam logic signed [AW-1:0] ANG_HALF = AW'(1 << (F - 1));
    localparam logic [ANG_TBL_W:0]   T_HALF   = (ANG_TBL_W + 1)'(1 << (ANG_FRAC - 1 - F));

    // config and capture state
    logic [CFG_W-1:0] portrait_reg, landscape_reg, same_axis_reg;
    logic             seen_reg, have_x_reg, have_y_reg, have_z_reg;
    logic [A-1:0]     x_reg, y_reg, z_reg;
    orient_t          cur_reg, cur_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // arithmetic
    logic [SQ_W-1:0]       sq_reg, sq_next, acc_reg, acc_next;
    logic [2*RW-1:0]       rad_reg, rad_next;
    logic [RW:0]           rem_reg, rem_next;
    logic [RW-1:0]         root_reg, root_next;
    logic signed [CW-1:0]  xv_reg, xv_next, yv_reg, yv_next;
    logic signed [AW-1:0]  ang_reg, ang_next;
    logic [DEG_W-1:0]      deg_reg, deg_next;
    orient_t               res_reg, res_next, out_reg, out_next;

    logic [EV_TYPE_W-1:0]  ev_type;
    logic [EV_CODE_W-1:0]  ev_code;
    logic [EV_VALUE_W-1:0] ev_value;
    logic [EV_VALUE_W-A:0] ev_top;
    logic [A-1:0]          sat_val;
    logic                  lat_x, lat_y, lat_z, is_report, complete;
    logic [A-1:0]          mag_x, mag_y, mag_z, mag_a, mag_b, mul_op;
    logic                  a_neg;
    logic [SQ_W-1:0]       mul_out;
    logic [RW+2:0]         rem_cat, trial;
    logic                  ge;
    logic signed [CW-1:0]  tx, ty;
    logic [ANG_TBL_W:0]    t_full;
    logic signed [AW-1:0]  t_step, ang_c, ang_rnd;
    logic [CFG_W-1:0]      thr;
    logic                  exceeds, on_axis;

    assign ev_type  = s_tdata[15:0];
    assign ev_code  = s_tdata[31:16];
    assign ev_value = s_tdata[63:32];

    always_comb
    begin
        ev_top  = ev_value[EV_VALUE_W-1:A-1];
        sat_val = ev_value[A-1:0];
        if (!((&ev_top) || !(|ev_top)))
        begin
            sat_val = ev_value[EV_VALUE_W-1] ? {1'b1, {(A-1){1'b0}}} : {1'b0, {(A-1){1'b1}}};
        end
    end

    assign lat_x     = seen_reg && (ev_type == EV_ABS) && (ev_code == ABS_X) && !have_x_reg;
    assign lat_y     = seen_reg && (ev_type == EV_ABS) && (ev_code == ABS_Y) && !have_y_reg;
    assign lat_z     = seen_reg && (ev_type == EV_ABS) && (ev_code == ABS_Z) && !have_z_reg;
    assign is_report = (ev_type == EV_SYN) && (ev_code == REPORT_CODE);
    assign complete  = (have_x_reg || lat_x) && (have_y_reg || lat_y) && (have_z_reg || lat_z);

    assign mag_x = x_reg[A-1] ? A'(~x_reg + 1'b1) : x_reg;
    assign mag_y = y_reg[A-1] ? A'(~y_reg + 1'b1) : y_reg;
    assign mag_z = z_reg[A-1] ? A'(~z_reg + 1'b1) : z_reg;
    assign mag_a = cmd.tilt_y ? mag_y : mag_x;
    assign mag_b = cmd.tilt_y ? mag_x : mag_y;
    assign a_neg = cmd.tilt_y ? y_reg[A-1] : x_reg[A-1];

    assign mul_op  = (cmd.op == OP_SQ_B) ? mag_b : mag_z;
    assign mul_out = mul_op * mul_op;

    // one root bit per step
    assign rem_cat = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign ge      = (rem_cat >= trial);

    assign tx     = xv_reg >>> step;
    assign ty     = yv_reg >>> step;
    assign t_full = {1'b0, step_angle(ANG_IDX_W'(step))} + T_HALF;
    assign t_step = $signed(AW'(t_full >> (ANG_FRAC - F)));

    always_comb
    begin
        ang_c = ang_reg;
        if (ang_reg < 0)
        begin
            ang_c = '0;
        end
        else if (ang_reg > ANG_LIM)
        begin
            ang_c = ANG_LIM;
        end
    end
    assign ang_rnd = ang_c + ANG_HALF;

    assign thr     = cmd.tilt_y ? landscape_reg : portrait_reg;
    assign exceeds = (deg_reg > thr);
    assign on_axis = cmd.tilt_y ? ((cur_reg == ORIENT_BOTTOM) || (cur_reg == ORIENT_NORMAL))
                                : ((cur_reg == ORIENT_LEFT) || (cur_reg == ORIENT_RIGHT));

    always_comb
    begin
        sq_next       = sq_reg;
        acc_next      = acc_reg;
        rad_next      = rad_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        xv_next       = xv_reg;
        yv_next       = yv_reg;
        ang_next      = ang_reg;
        deg_next      = deg_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        cur_next      = cur_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                if (complete)
                begin
                    res_next = cur_reg;
                end
            end
            OP_SQ_B:
            begin
                sq_next = mul_out;
            end
            OP_SQ_C:
            begin
                acc_next = sq_reg;
                sq_next  = mul_out;
            end
            OP_SUM:
            begin
                rad_next  = {SQ_W'(acc_reg + sq_reg), {(2 * ROOT_FRAC){1'b0}}};
                rem_next  = '0;
                root_next = '0;
            end
            OP_ROOT:
            begin
                rad_next  = rad_reg << 2;
                rem_next  = ge ? (RW + 1)'(rem_cat - trial) : (RW + 1)'(rem_cat);
                root_next = {root_reg[RW-2:0], ge};
            end
            OP_CINIT:
            begin
                xv_next  = $signed({3'b000, root_reg});
                yv_next  = $signed({3'b000, mag_a, {ROOT_FRAC{1'b0}}});
                ang_next = '0;
            end
            OP_ROT:
            begin
                if (!yv_reg[CW-1])
                begin
                    xv_next  = xv_reg + ty;
                    yv_next  = yv_reg - tx;
                    ang_next = ang_reg + t_step;
                end
                else
                begin
                    xv_next  = xv_reg - ty;
                    yv_next  = yv_reg + tx;
                    ang_next = ang_reg - t_step;
                end
            end
            OP_ROUND:
            begin
                if (mag_a == '0)
                begin
                    deg_next = '0;
                end
                else if (root_reg == '0)
                begin
                    deg_next = DEG_W'(MAX_DEG);
                end
                else
                begin
                    deg_next = ang_rnd[F+DEG_W-1:F];
                end
            end
            OP_DECIDE:
            begin
                if (exceeds)
                begin
                    if (on_axis && (deg_reg < same_axis_reg))
                    begin
                        res_next = cur_reg;
                    end
                    else if (cmd.tilt_y)
                    begin
                        res_next = a_neg ? ORIENT_BOTTOM : ORIENT_NORMAL;
                    end
                    else
                    begin
                        res_next = a_neg ? ORIENT_LEFT : ORIENT_RIGHT;
                    end
                end
            end
            OP_EMIT:
            begin
                out_next      = res_reg;
                cur_next      = res_reg;
                m_tvalid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            portrait_reg  <= PORTRAIT_RST;
            landscape_reg <= LANDSCAPE_RST;
            same_axis_reg <= SAME_AXIS_RST;
            seen_reg      <= 1'b0;
            have_x_reg    <= 1'b0;
            have_y_reg    <= 1'b0;
            have_z_reg    <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            cur_reg       <= ORIENT_UNDEF;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            cur_reg      <= cur_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PORTRAIT:  portrait_reg  <= cfg_data;
                    CFG_LANDSCAPE: landscape_reg <= cfg_data;
                    CFG_SAME_AXIS: same_axis_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == OP_CAPTURE)
            begin
                if (lat_x)
                begin
                    x_reg <= sat_val;
                end
                if (lat_y)
                begin
                    y_reg <= sat_val;
                end
                if (lat_z)
                begin
                    z_reg <= sat_val;
                end
                if (complete)
                begin
                    seen_reg   <= 1'b0;
                    have_x_reg <= 1'b0;
                    have_y_reg <= 1'b0;
                    have_z_reg <= 1'b0;
                end
                else
                begin
                    have_x_reg <= have_x_reg || lat_x;
                    have_y_reg <= have_y_reg || lat_y;
                    have_z_reg <= have_z_reg || lat_z;
                    if (is_report)
                    begin
                        seen_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        xv_reg   <= xv_next;
        yv_reg   <= yv_next;
        ang_reg  <= ang_next;
        deg_reg  <= deg_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign status.complete = complete;
    assign status.zero_vec = (x_reg == '0) && (y_reg == '0) && (z_reg == '0);
    assign status.exceeds  = exceeds;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - 3){1'b0}}, out_reg};

endmodule

// File: src/accel_orientation_detector_unit.sv
// Accelerometer orientation detector top level: controller plus datapath.
// Events that do not complete an X/Y/Z capture transfer at one per cycle.
// A completing event ends intake; an all-zero vector is reported without tilt passes,
// else the x tilt pass decides, or a y tilt pass follows when x does not exceed; each pass
// squares, takes the root one bit per cycle and runs CORDIC one step per cycle.
// rst_n asynchronous, active low: registers 20/25/5, orientation undefined, capture cleared.
module accel_orientation_detector_unit #(
    parameter int AXIS_BITS       = 16,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [aod_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aod_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // event_type [15:0], event_code [31:16], event_value [63:32]
    input  logic [aod_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // orientation [2:0], zeros [7:3]
    output logic [aod_pkg::M_DATA_W-1:0]  m_tdata
);
    import aod_pkg::*;

    localparam int ROOT_STEPS = AXIS_BITS + ROOT_FRAC;
    localparam int MAX_STEPS  = (ROOT_STEPS > CORDIC_STEPS) ? ROOT_STEPS : CORDIC_STEPS;
    localparam int CNT_W      = $clog2(MAX_STEPS);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [CNT_W-1:0] step;

    aod_ctrl #(
        .ROOT_STEPS   (ROOT_STEPS),
        .CORDIC_STEPS (CORDIC_STEPS),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .step     (step)
    );

    aod_datapath #(
        .AXIS_BITS       (AXIS_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CNT_W           (CNT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .step      (step),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: src/aod_checker.sv
// Port-level checks for the orientation detector, bound to the top level.
// Depends on aod_pkg and accel_orientation_detector_unit.
module aod_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [aod_pkg::M_DATA_W-1:0] m_tdata
);
    import aod_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= M_DATA_W'(ORIENT_RIGHT)))
        else $error("orientation code out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("input stalled without a completing transfer");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (!$past(m_tvalid) || $past(m_tready)) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared right after an input transfer");

endmodule

bind accel_orientation_detector_unit aod_checker u_aod_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/tb_accel_orientation_detector_unit.sv
// Self-checking bench for accel_orientation_detector_unit: event stream in, orientation out.
// A built-in predictor of the capture, tilt and decision logic checks every result.
// Depends on aod_pkg and the block's RTL only.
module tb_accel_orientation_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import aod_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int LONG_HOLD = 400;
    localparam int EVENTS_PER_PHASE = 105;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    accel_orientation_detector_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [CFG_W-1:0] portrait_lim = PORTRAIT_RST;
    logic [CFG_W-1:0] landscape_lim = LANDSCAPE_RST;
    logic [CFG_W-1:0] hold_lim = SAME_AXIS_RST;
    bit sync_seen, got_x, got_y, got_z;
    logic signed [15:0] x_held, y_held, z_held;
    orient_t last_orient = ORIENT_UNDEF;

    logic [S_DATA_W-1:0] event_q[$];
    orient_t orient_q[$];

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned events_sent = 0;
    int unsigned results_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    bit no_gaps = 1'b0;
    int unsigned hold_request = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned rx_mode = 0;
    int unsigned mode_left = 0;
    orient_t want_orient;

    task automatic log_mismatch(input string msg);
        if (error_count < 50)
            $display("mismatch, cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // atan(2^-i) in degrees, 8 fractional bits, rounded half up from 16
    function automatic longint atan_step(input int i);
        longint a;
        case (i)
            0:       a = 2949120;
            1:       a = 1740967;
            2:       a = 919879;
            3:       a = 466945;
            4:       a = 234379;
            5:       a = 117304;
            6:       a = 58666;
            7:       a = 29335;
            8:       a = 14668;
            9:       a = 7334;
            10:      a = 3667;
            11:      a = 1833;
            12:      a = 917;
            13:      a = 458;
            14:      a = 229;
            15:      a = 115;
            default: a = 0;
        endcase
        return (a + 128) >>> 8;
    endfunction

    function automatic longint int_sqrt(input longint v);
        longint r;
        longint cand;
        int k;
        r = 0;
        for (k = 24; k >= 0; k--)
        begin
            cand = r | (longint'(1) <<< k);
            if (cand * cand <= v)
                r = cand;
        end
        return r;
    endfunction

    // rounded degrees of atan(a / sqrt(b^2 + c^2)), sign of a
    function automatic int tilt_degrees(input logic signed [15:0] a,
                                        input logic signed [15:0] b,
                                        input logic signed [15:0] c);
        longint ua, ub, uc, den, num, xv, yv, tx, ty, ang;
        int deg;
        int i;
        ua = (a < 0) ? -longint'(a) : longint'(a);
        ub = (b < 0) ? -longint'(b) : longint'(b);
        uc = (c < 0) ? -longint'(c) : longint'(c);
        den = int_sqrt((ub * ub + uc * uc) <<< 16);
        num = ua <<< 8;
        ang = 0;
        if (num == 0)
            return 0;
        if (den == 0)
            deg = 90;
        else
        begin
            xv = den;
            yv = num;
            for (i = 0; i < 16; i++)
            begin
                tx = xv >>> i;
                ty = yv >>> i;
                if (yv >= 0)
                begin
                    xv = xv + ty;
                    yv = yv - tx;
                    ang = ang + atan_step(i);
                end
                else
                begin
                    xv = xv - ty;
                    yv = yv + tx;
                    ang = ang - atan_step(i);
                end
            end
            if (ang < 0)
                ang = 0;
            if (ang > (90 <<< 8))
                ang = 90 <<< 8;
            deg = int'((ang + 128) >>> 8);
        end
        return (a < 0) ? -deg : deg;
    endfunction

    function automatic orient_t next_orientation(input orient_t prev);
        orient_t res;
        int rot, mag;
        res = prev;
        if (x_held == 0 && y_held == 0 && z_held == 0)
            return prev;
        rot = tilt_degrees(x_held, y_held, z_held);
        mag = (rot < 0) ? -rot : rot;
        if (mag > int'(portrait_lim))
        begin
            res = (rot < 0) ? ORIENT_LEFT : ORIENT_RIGHT;
            if ((prev == ORIENT_LEFT || prev == ORIENT_RIGHT) && mag < int'(hold_lim))
                res = prev;
        end
        else
        begin
            rot = tilt_degrees(y_held, x_held, z_held);
            mag = (rot < 0) ? -rot : rot;
            if (mag > int'(landscape_lim))
            begin
                res = (rot < 0) ? ORIENT_BOTTOM : ORIENT_NORMAL;
                if ((prev == ORIENT_BOTTOM || prev == ORIENT_NORMAL) && mag < int'(hold_lim))
                    res = prev;
            end
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp_axis(input logic [31:0] raw);
        logic signed [31:0] v;
        v = raw;
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic absorb_event(input logic [S_DATA_W-1:0] d);
        logic [EV_TYPE_W-1:0] ev_type;
        logic [EV_CODE_W-1:0] ev_code;
        ev_type = d[15:0];
        ev_code = d[31:16];
        if (sync_seen && ev_type == EV_ABS)
        begin
            if (ev_code == ABS_X && !got_x)
            begin
                x_held = clamp_axis(d[63:32]);
                got_x = 1'b1;
            end
            else if (ev_code == ABS_Y && !got_y)
            begin
                y_held = clamp_axis(d[63:32]);
                got_y = 1'b1;
            end
            else if (ev_code == ABS_Z && !got_z)
            begin
                z_held = clamp_axis(d[63:32]);
                got_z = 1'b1;
            end
        end
        if (ev_type == EV_SYN && ev_code == REPORT_CODE)
            sync_seen = 1'b1;
        if (got_x && got_y && got_z)
        begin
            last_orient = next_orientation(last_orient);
            orient_q.push_back(last_orient);
            sync_seen = 1'b0;
            got_x = 1'b0;
            got_y = 1'b0;
            got_z = 1'b0;
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                absorb_event(s_tdata);
                events_sent++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (event_q.size() > 0)
                begin
                    s_tdata <= event_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        if (no_gaps || $urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each transfer, stalls on its own pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (orient_q.size() == 0)
                    log_mismatch($sformatf("orientation %0d with nothing outstanding",
                                           m_tdata[2:0]));
                else
                begin
                    want_orient = orient_q.pop_front();
                    if (m_tdata[2:0] !== want_orient)
                        log_mismatch($sformatf("orientation %0d, predicted %0d",
                                               m_tdata[2:0], want_orient));
                end
            end
            if (hold_request != hold_served)
            begin
                hold_served = hold_request;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= (cycle_count % 5 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, orient_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
                               input logic [31:0] ev_value);
        event_q.push_back({ev_value, ev_code, ev_type});
    endtask

    function automatic logic [31:0] axis_reading();
        int v;
        case ($urandom_range(0, 11))
            0:       v = $urandom;
            1:       v = 0;
            2:       v = int'($urandom_range(0, 16)) - 8;
            3:       v = int'($urandom_range(0, 65535)) - 32768;
            4:       v = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            5:       v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            6:       v = ($urandom_range(0, 1) != 0) ? 32768 : -32769;
            default: v = int'($urandom_range(0, 4000)) - 2000;
        endcase
        return v;
    endfunction

    task automatic queue_noise();
        logic [15:0] ev_type;
        case ($urandom_range(0, 3))
            0:       ev_type = EV_SYN;
            1:       ev_type = EV_ABS;
            default: ev_type = 16'($urandom);
        endcase
        queue_event(ev_type, ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 4)),
                    $urandom);
    endtask

    // capture: sync, X, Y, Z in random order, optional repeats and noise; broken skips some
    task automatic queue_capture(input bit broken, inout int unsigned counted);
        logic [15:0] axis_code[3];
        logic [15:0] tmp;
        int j, k;
        axis_code[0] = ABS_X;
        axis_code[1] = ABS_Y;
        axis_code[2] = ABS_Z;
        for (j = 2; j > 0; j--)
        begin
            k = $urandom_range(0, j);
            tmp = axis_code[j];
            axis_code[j] = axis_code[k];
            axis_code[k] = tmp;
        end
        if (!broken || $urandom_range(0, 1) != 0)
            queue_event(EV_SYN, REPORT_CODE, ($urandom_range(0, 3) == 0) ? $urandom : 32'd0);
        counted++;
        for (j = 0; j < 3; j++)
        begin
            if (broken && $urandom_range(0, 2) == 0)
                continue;
            if ($urandom_range(0, 7) == 0)
                queue_noise();
            queue_event(EV_ABS, axis_code[j], axis_reading());
            counted++;
            if ($urandom_range(0, 9) == 0)
                queue_event(EV_ABS, axis_code[$urandom_range(0, j)], axis_reading());
            if ($urandom_range(0, 15) == 0)
                queue_event(EV_SYN, REPORT_CODE, 32'd0);
        end
    endtask

    task automatic wait_idle();
        while (event_q.size() != 0 || s_tvalid || orient_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_PORTRAIT)
            portrait_lim = val;
        else if (idx == CFG_LANDSCAPE)
            landscape_lim = val;
        else if (idx == CFG_SAME_AXIS)
            hold_lim = val;
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] l,
                                  input logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(CFG_SAME_AXIS, h);
        write_reg(CFG_PORTRAIT, p);
        write_reg(CFG_LANDSCAPE, l);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned counted;
        int unsigned pick;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                queue_capture(1'b0, counted);
            else if (pick == 7)
                queue_capture(1'b1, counted);
            else
                queue_noise();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // axis reading before any sync report is dropped
        queue_event(EV_ABS, ABS_X, 32'd100);
        // saturating positive X, flat otherwise: right-up
        queue_event(EV_SYN, REPORT_CODE, 32'd0);
        queue_event(EV_ABS, ABS_X, 32'h7FFF_FFFF);
        queue_event(EV_ABS, ABS_Y, 32'd0);
        queue_event(EV_ABS, ABS_Z, 32'd0);
        // saturating negative X, repeated X ignored: left-up
        queue_event(EV_SYN, REPORT_CODE, 32'hFFFF_FFFF);
        queue_event(EV_ABS, ABS_X, 32'h8000_0000);
        queue_event(EV_ABS, ABS_Y, 32'd5);
        queue_event(EV_ABS, ABS_X, 32'd7);
        queue_event(EV_ABS, ABS_Z, 32'd0);
        // all-zero vector keeps the previous orientation
        queue_event(EV_SYN, REPORT_CODE, 32'd0);
        queue_event(EV_ABS, ABS_Z, 32'd0);
        queue_event(EV_ABS, ABS_Y, 32'd0);
        queue_event(EV_ABS, ABS_X, 32'd0);
        // unknown type and code in between: bottom-up
        queue_event(EV_SYN, REPORT_CODE, 32'd0);
        queue_event(16'hFFFF, 16'hFFFF, 32'd0);
        queue_event(EV_ABS, 16'd5, 32'd1234);
        queue_event(EV_ABS, ABS_Y, -32'sd1000);
        queue_event(EV_ABS, ABS_X, 32'd0);
        queue_event(EV_ABS, ABS_Z, 32'd100);
        // zero numerator on both tilts: kept
        queue_event(EV_SYN, REPORT_CODE, 32'd0);
        queue_event(EV_ABS, ABS_X, 32'd0);
        queue_event(EV_ABS, ABS_Y, 32'd0);
        queue_event(EV_ABS, ABS_Z, 32'd500);

        wait_idle();
        run_random(EVENTS_PER_PHASE);

        apply_settings(7'd0, 7'd0, 7'd0);
        run_random(EVENTS_PER_PHASE);

        // receiver holds off while the sender keeps offering
        apply_settings(7'd90, 7'd90, 7'd90);
        no_gaps = 1'b1;
        hold_request++;
        run_random(EVENTS_PER_PHASE);
        wait_idle();
        no_gaps = 1'b0;

        // same-axis hold above the thresholds
        apply_settings(7'd10, 7'd10, 7'd60);
        run_random(EVENTS_PER_PHASE);

        apply_settings(7'd127, 7'd127, 7'd127);
        write_reg(CFG_SPARE, 7'h55);
        @(posedge clk);
        cfg_we <= 1'b0;
        run_random(EVENTS_PER_PHASE);

        apply_settings(7'($urandom_range(0, 90)), 7'($urandom_range(0, 90)),
                       7'($urandom_range(0, 90)));
        run_random(EVENTS_PER_PHASE);

        wait_idle();
        while (orient_q.size() != 0)
            log_mismatch($sformatf("orientation %0d never arrived", orient_q.pop_front()));
        $display("covered %0d events, %0d orientation results, %0d register writes",
                 events_sent, results_seen, reg_writes);
        $display("six threshold settings, one long output stall, %0d errors", error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
src/aod_pkg.sv
src/aod_ctrl.sv
src/aod_datapath.sv
src/accel_orientation_detector_unit.sv
src/aod_checker.sv
bench/tb_accel_orientation_detector_unit.sv
